### hdl/bda_pkg.sv
// Shared types and constants for the button debounce and auto-repeat block.
package bda_pkg;

	localparam int NUM_BUTTONS = 4;
	localparam int TICK_W      = 16;
	localparam int PIN_W       = 4;
	localparam int INDEX_W     = 2;
	localparam int CFG_W       = 16;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	localparam logic [CFG_W-1:0] PUSH_SETTLE_RST   = 16'd10;
	localparam logic [CFG_W-1:0] RELEASE_SETTLE_RST = 16'd30;
	localparam logic [CFG_W-1:0] HOLD_DELAY_RST    = 16'd400;
	localparam logic [CFG_W-1:0] REPEAT_PERIOD_RST = 16'd130;

	localparam logic [1:0] REG_PUSH_SETTLE    = 2'd0;
	localparam logic [1:0] REG_RELEASE_SETTLE = 2'd1;
	localparam logic [1:0] REG_HOLD_DELAY     = 2'd2;
	localparam logic [1:0] REG_REPEAT_PERIOD  = 2'd3;

	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_POLL = 1'b1;

	typedef enum logic [3:0] {
		MODE_IDLE     = 4'b0001,
		MODE_PUSHED   = 4'b0010,
		MODE_RELEASED = 4'b0100,
		MODE_HELD     = 4'b1000
	} mode_t;

	typedef struct packed {
		logic [CFG_W-1:0] push_settle;
		logic [CFG_W-1:0] release_settle;
		logic [CFG_W-1:0] hold_delay;
		logic [CFG_W-1:0] repeat_period;
	} cfg_t;

	typedef struct packed {
		logic              poll;
		logic              edge_hit;
		logic [TICK_W-1:0] tick;
	} lane_req_t;

endpackage

### hdl/bda_lane.sv
// One button lane: mode machine, edge flag and timestamp.
module bda_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  bda_pkg::cfg_t      cfg,
	input  bda_pkg::lane_req_t req,
	input  logic               pin_high,
	output logic               press
);

	bda_pkg::mode_t                 mode_q, mode_d;
	logic                           pend_q, pend_d;
	logic [bda_pkg::TICK_W-1:0]     stamp_q, stamp_d;
	logic [bda_pkg::TICK_W-1:0]     elapsed;

	assign elapsed = req.tick - stamp_q;

	always_comb begin
		mode_d  = mode_q;
		pend_d  = pend_q;
		stamp_d = stamp_q;
		press   = 1'b0;
		if (req.edge_hit) begin
			pend_d  = 1'b1;
			stamp_d = req.tick;
		end else if (req.poll) begin
			case (mode_q)
				bda_pkg::MODE_IDLE: begin
					if (pend_q && elapsed >= cfg.push_settle) begin
						if (!pin_high) begin
							mode_d = bda_pkg::MODE_PUSHED;
							press  = 1'b1;
						end else begin
							mode_d = bda_pkg::MODE_RELEASED;
						end
						stamp_d = req.tick;
						pend_d  = 1'b0;
					end
				end
				bda_pkg::MODE_PUSHED: begin
					if (elapsed >= cfg.hold_delay) begin
						mode_d  = bda_pkg::MODE_HELD;
						stamp_d = req.tick;
					end
					pend_d = 1'b0;
					if (pin_high) mode_d = bda_pkg::MODE_RELEASED;
				end
				bda_pkg::MODE_RELEASED: begin
					if (elapsed >= cfg.release_settle) begin
						mode_d = bda_pkg::MODE_IDLE;
					end else if (pend_q) begin
						stamp_d = req.tick;
					end
					pend_d = 1'b0;
				end
				bda_pkg::MODE_HELD: begin
					if (elapsed >= cfg.repeat_period) begin
						stamp_d = req.tick;
						press   = 1'b1;
					end
					if (pend_q || pin_high) mode_d = bda_pkg::MODE_RELEASED;
					pend_d = 1'b0;
				end
				default: begin
					mode_d = bda_pkg::MODE_IDLE;
					pend_d = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= bda_pkg::MODE_IDLE;
			pend_q  <= 1'b0;
			stamp_q <= '0;
		end else begin
			mode_q  <= mode_d;
			pend_q  <= pend_d;
			stamp_q <= stamp_d;
		end
	end

endmodule

### hdl/bda_merge.sv
// Merge of lane press bits into the registered result mask.
module bda_merge #(
	parameter int NUM_BUTTONS = bda_pkg::NUM_BUTTONS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      poll_accept,
	input  logic [NUM_BUTTONS-1:0]    lane_press,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [bda_pkg::PIN_W-1:0] press_mask
);

	logic [bda_pkg::PIN_W-1:0] mask_d;
	logic                      valid_q;
	logic [bda_pkg::PIN_W-1:0] mask_q;

	for (genvar i = 0; i < bda_pkg::PIN_W; i++) begin : g_bit
		if (i < NUM_BUTTONS) begin : g_lane
			assign mask_d[i] = lane_press[i];
		end else begin : g_pad
			assign mask_d[i] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (poll_accept) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_accept) mask_q <= mask_d;
	end

	assign out_valid  = valid_q;
	assign press_mask = mask_q;

endmodule

### hdl/button_debounce_autorepeat_top.sv
// Top level of the button debounce and auto-repeat block.
//
// Input channel (in_valid/in_ready) carries one request per item: opcode 0
// is an edge on button_index, stamped with tick_now; opcode 1 is a poll that
// samples pin_levels (1 = released) against tick_now for every button.
// An edge request produces no result; a poll request produces one result on
// the output channel (out_valid/out_ready) carrying press_mask.
// A poll's result is registered in the output register that drives the output channel.
// Throughput: one request per cycle while in_ready is high; all button lanes update in parallel and
// one output register holds the merged mask.
// in_ready is high while the output register is empty or being drained, so a
// stalled receiver holds back the next request only while a result waits.
// Settle, hold and repeat times sit in four 16-bit APB registers at byte
// addresses 0, 4, 8 and 12, written with psel/penable/pwrite high.
// Reset (arst_n low) sets every button to idle with no pending edge and a
// zero stamp, loads the register defaults 10, 30, 400 and 130, and empties
// the output register.
module button_debounce_autorepeat_top #(
	parameter int NUM_BUTTONS = bda_pkg::NUM_BUTTONS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bda_pkg::ADDR_W-1:0]  paddr,
	input  logic [bda_pkg::DATA_W-1:0]  pwdata,
	output logic [bda_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        opcode,
	input  logic [bda_pkg::TICK_W-1:0]  tick_now,
	input  logic [bda_pkg::INDEX_W-1:0] button_index,
	input  logic [bda_pkg::PIN_W-1:0]   pin_levels,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bda_pkg::PIN_W-1:0]   press_mask
);

	bda_pkg::cfg_t          cfg_q;
	logic                   cfg_write;
	logic [1:0]             reg_sel;
	logic [bda_pkg::CFG_W-1:0] rd_value;
	logic                   in_accept;
	logic                   poll_accept;
	logic [NUM_BUTTONS-1:0] lane_press;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign reg_sel   = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.push_settle    <= bda_pkg::PUSH_SETTLE_RST;
			cfg_q.release_settle <= bda_pkg::RELEASE_SETTLE_RST;
			cfg_q.hold_delay     <= bda_pkg::HOLD_DELAY_RST;
			cfg_q.repeat_period  <= bda_pkg::REPEAT_PERIOD_RST;
		end else if (cfg_write) begin
			case (reg_sel)
				bda_pkg::REG_PUSH_SETTLE:    cfg_q.push_settle    <= pwdata[15:0];
				bda_pkg::REG_RELEASE_SETTLE: cfg_q.release_settle <= pwdata[15:0];
				bda_pkg::REG_HOLD_DELAY:     cfg_q.hold_delay     <= pwdata[15:0];
				bda_pkg::REG_REPEAT_PERIOD:  cfg_q.repeat_period  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			bda_pkg::REG_PUSH_SETTLE:    rd_value = cfg_q.push_settle;
			bda_pkg::REG_RELEASE_SETTLE: rd_value = cfg_q.release_settle;
			bda_pkg::REG_HOLD_DELAY:     rd_value = cfg_q.hold_delay;
			bda_pkg::REG_REPEAT_PERIOD:  rd_value = cfg_q.repeat_period;
			default:                     rd_value = '0;
		endcase
	end

	assign prdata = {{(bda_pkg::DATA_W-bda_pkg::CFG_W){1'b0}}, rd_value};

	assign in_ready    = !out_valid || out_ready;
	assign in_accept   = in_valid && in_ready;
	assign poll_accept = in_accept && (opcode == bda_pkg::OP_POLL);

	for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
		bda_pkg::lane_req_t req;
		logic               pin_high;

		assign req.poll     = poll_accept;
		assign req.edge_hit = in_accept && (opcode == bda_pkg::OP_EDGE)
			&& (32'(button_index) == b);
		assign req.tick     = tick_now;

		if (b < bda_pkg::PIN_W) begin : g_pin
			assign pin_high = pin_levels[b];
		end else begin : g_nopin
			assign pin_high = 1'b1;
		end

		bda_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.cfg      (cfg_q),
			.req      (req),
			.pin_high (pin_high),
			.press    (lane_press[b])
		);
	end

	bda_merge #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.poll_accept (poll_accept),
		.lane_press  (lane_press),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.press_mask  (press_mask)
	);

`ifndef NO_ASSERTIONS
	a_poll_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		poll_accept |=> out_valid)
		else $error("poll request did not produce a result");

	a_edge_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && opcode == bda_pkg::OP_EDGE && !out_valid) |=> !out_valid)
		else $error("edge request produced a result");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_write && reg_sel == bda_pkg::REG_PUSH_SETTLE)
		|=> cfg_q.push_settle == $past(pwdata[15:0]))
		else $error("push settle register not written");
`endif

endmodule

### tb/button_debounce_autorepeat_top_test.sv
// Self-checking testbench for the button debounce and auto-repeat block.
`timescale 1ns / 100ps

module button_debounce_autorepeat_top_test;
	import bda_pkg::*;

	localparam int LONG_HOLD   = 150;
	localparam int DRAIN_LIMIT = 2000;
	localparam int DIR_ROWS    = 25;

	typedef struct packed {
		logic               op;
		logic [TICK_W-1:0]  tick;
		logic [INDEX_W-1:0] idx;
		logic [PIN_W-1:0]   pins;
		logic               known;
		logic [PIN_W-1:0]   mask;
	} dir_row_t;

	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		'{OP_POLL, 16'd0,     2'd0, 4'hF, 1'b1, 4'h0},
		'{OP_EDGE, 16'd100,   2'd0, 4'hF, 1'b0, 4'h0},
		'{OP_POLL, 16'd105,   2'd0, 4'hE, 1'b1, 4'h0},
		'{OP_POLL, 16'd110,   2'd0, 4'hE, 1'b1, 4'h1},
		'{OP_POLL, 16'd200,   2'd0, 4'hE, 1'b0, 4'h0},
		'{OP_POLL, 16'd510,   2'd0, 4'hE, 1'b1, 4'h0},
		'{OP_POLL, 16'd640,   2'd0, 4'hE, 1'b1, 4'h1},
		'{OP_POLL, 16'd700,   2'd0, 4'hE, 1'b0, 4'h0},
		'{OP_POLL, 16'd770,   2'd0, 4'hF, 1'b1, 4'h1},
		'{OP_POLL, 16'd790,   2'd0, 4'hF, 1'b0, 4'h0},
		'{OP_EDGE, 16'd65530, 2'd1, 4'h0, 1'b0, 4'h0},
		'{OP_POLL, 16'd4,     2'd0, 4'hD, 1'b1, 4'h2},
		'{OP_EDGE, 16'd5,     2'd1, 4'hF, 1'b0, 4'h0},
		'{OP_POLL, 16'd6,     2'd0, 4'hF, 1'b0, 4'h0},
		'{OP_EDGE, 16'd7,     2'd1, 4'h0, 1'b0, 4'h0},
		'{OP_POLL, 16'd20,    2'd0, 4'hF, 1'b0, 4'h0},
		'{OP_EDGE, 16'd1000,  2'd2, 4'hF, 1'b0, 4'h0},
		'{OP_EDGE, 16'd1000,  2'd3, 4'h0, 1'b0, 4'h0},
		'{OP_POLL, 16'd1010,  2'd0, 4'h3, 1'b1, 4'hC},
		'{OP_POLL, 16'd1410,  2'd0, 4'h3, 1'b0, 4'h0},
		'{OP_POLL, 16'd1540,  2'd0, 4'h3, 1'b0, 4'h0},
		'{OP_EDGE, 16'd1541,  2'd2, 4'hF, 1'b0, 4'h0},
		'{OP_POLL, 16'd1600,  2'd0, 4'h3, 1'b0, 4'h0},
		'{OP_POLL, 16'hFFFF,  2'd3, 4'h0, 1'b0, 4'h0},
		'{OP_EDGE, 16'hFFFF,  2'd3, 4'hF, 1'b0, 4'h0}
	};

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid;
	logic                in_ready;
	logic                opcode;
	logic [TICK_W-1:0]   tick_now;
	logic [INDEX_W-1:0]  button_index;
	logic [PIN_W-1:0]    pin_levels;
	logic                out_valid;
	logic                out_ready;
	logic [PIN_W-1:0]    press_mask;

	cfg_t                cfg;
	mode_t               btn_mode  [NUM_BUTTONS];
	logic                btn_edge  [NUM_BUTTONS];
	logic [TICK_W-1:0]   btn_stamp [NUM_BUTTONS];

	logic [PIN_W-1:0]    expected_masks [$];
	logic [PIN_W-1:0]    exp_mask;
	int                  mismatch_count = 0;
	bit                  no_idle = 1'b0;
	bit                  long_hold = 1'b0;
	logic [TICK_W-1:0]   cur_tick = '0;
	logic [PIN_W-1:0]    pin_state = '1;

	button_debounce_autorepeat_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.tick_now     (tick_now),
		.button_index (button_index),
		.pin_levels   (pin_levels),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.press_mask   (press_mask)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void debounce_reset();
		int b;
		cfg.push_settle    = PUSH_SETTLE_RST;
		cfg.release_settle = RELEASE_SETTLE_RST;
		cfg.hold_delay     = HOLD_DELAY_RST;
		cfg.repeat_period  = REPEAT_PERIOD_RST;
		for (b = 0; b < NUM_BUTTONS; b++) begin
			btn_mode[b]  = MODE_IDLE;
			btn_edge[b]  = 1'b0;
			btn_stamp[b] = '0;
		end
	endfunction

	function automatic void mark_edge(logic [INDEX_W-1:0] idx, logic [TICK_W-1:0] now);
		if (int'(idx) < NUM_BUTTONS) begin
			btn_edge[idx]  = 1'b1;
			btn_stamp[idx] = now;
		end
	endfunction

	function automatic logic [PIN_W-1:0] debounce_poll(logic [TICK_W-1:0] now,
			logic [PIN_W-1:0] pins);
		logic [PIN_W-1:0]  mask;
		logic [TICK_W-1:0] el;
		logic              high;
		int                b;
		mask = '0;
		for (b = 0; b < NUM_BUTTONS; b++) begin
			high = pins[b];
			el   = now - btn_stamp[b];
			case (btn_mode[b])
				MODE_IDLE: begin
					if (btn_edge[b] && el >= cfg.push_settle) begin
						if (!high) begin
							btn_mode[b] = MODE_PUSHED;
							mask[b]     = 1'b1;
						end else begin
							btn_mode[b] = MODE_RELEASED;
						end
						btn_stamp[b] = now;
						btn_edge[b]  = 1'b0;
					end
				end
				MODE_PUSHED: begin
					if (el >= cfg.hold_delay) begin
						btn_mode[b]  = MODE_HELD;
						btn_stamp[b] = now;
					end
					btn_edge[b] = 1'b0;
					if (high) btn_mode[b] = MODE_RELEASED;
				end
				MODE_RELEASED: begin
					if (el >= cfg.release_settle) begin
						btn_mode[b] = MODE_IDLE;
						btn_edge[b] = 1'b0;
					end
					if (btn_edge[b]) begin
						btn_stamp[b] = now;
						btn_edge[b]  = 1'b0;
					end
				end
				default: begin
					if (el >= cfg.repeat_period) begin
						btn_stamp[b] = now;
						mask[b]      = 1'b1;
					end
					if (btn_edge[b]) begin
						btn_mode[b] = MODE_RELEASED;
						btn_edge[b] = 1'b0;
					end
					if (high) btn_mode[b] = MODE_RELEASED;
				end
			endcase
		end
		return mask;
	endfunction

	task automatic send_req(logic op, logic [TICK_W-1:0] tick, logic [INDEX_W-1:0] idx,
			logic [PIN_W-1:0] pins, logic known, logic [PIN_W-1:0] known_mask);
		int               gap;
		logic [PIN_W-1:0] m;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		tick_now     <= tick;
		button_index <= idx;
		pin_levels   <= pins;
		do @(posedge clk); while (!in_ready);
		if (op == OP_POLL) begin
			m = debounce_poll(tick, pins);
			expected_masks.push_back(known ? known_mask : m);
		end else begin
			mark_edge(idx, tick);
		end
	endtask

	task automatic drain();
		int n;
		in_valid <= 1'b0;
		n = 0;
		while (expected_masks.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (4) @(posedge clk);
		if (expected_masks.size() != 0) begin
			$display("%0t: %0d press_mask results never arrived", $time,
				expected_masks.size());
			mismatch_count++;
			expected_masks.delete();
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_PUSH_SETTLE:    cfg.push_settle    = val;
			REG_RELEASE_SETTLE: cfg.release_settle = val;
			REG_HOLD_DELAY:     cfg.hold_delay     = val;
			default:            cfg.repeat_period  = val;
		endcase
	endtask

	task automatic set_config(logic [CFG_W-1:0] push, logic [CFG_W-1:0] rel,
			logic [CFG_W-1:0] hold, logic [CFG_W-1:0] rep);
		drain();
		write_reg(REG_PUSH_SETTLE, push);
		write_reg(REG_RELEASE_SETTLE, rel);
		write_reg(REG_HOLD_DELAY, hold);
		write_reg(REG_REPEAT_PERIOD, rep);
	endtask

	task automatic random_phase(int count, int step_max, int hold_at);
		int               k;
		int               b;
		logic [PIN_W-1:0] bounce;
		for (k = 0; k < count; k++) begin
			if (k == hold_at) long_hold = 1'b1;
			if ($urandom_range(0, 99) < 3)
				cur_tick = 16'($urandom);
			else
				cur_tick = cur_tick + 16'($urandom_range(0, step_max));
			if ($urandom_range(0, 99) < 25) begin
				b = $urandom_range(0, NUM_BUTTONS - 1);
				// most edges are real presses or releases, the rest are bounce
				if ($urandom_range(0, 3) != 0) pin_state[b] = ~pin_state[b];
				send_req(OP_EDGE, cur_tick, 2'(b), 4'($urandom), 1'b0, '0);
			end else begin
				bounce = ($urandom_range(0, 99) < 10) ? 4'($urandom) : 4'h0;
				send_req(OP_POLL, cur_tick, 2'($urandom), pin_state ^ bounce, 1'b0, '0);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_masks.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual press_mask=%h",
					$time, press_mask);
				mismatch_count++;
			end else begin
				exp_mask = expected_masks.pop_front();
				if (press_mask !== exp_mask) begin
					$display("%0t: press_mask mismatch, expected %h, actual %h",
						$time, exp_mask, press_mask);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : receiver
		int w;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
			end
			w = no_idle ? 0 : $urandom_range(0, 4);
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : stimulus
		int i;
		arst_n       <= 1'b0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		in_valid     <= 1'b0;
		opcode       <= OP_EDGE;
		tick_now     <= '0;
		button_index <= '0;
		pin_levels   <= '1;
		debounce_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIR_ROWS; i++)
			send_req(DIR_TAB[i].op, DIR_TAB[i].tick, DIR_TAB[i].idx, DIR_TAB[i].pins,
				DIR_TAB[i].known, DIR_TAB[i].mask);
		cur_tick = 16'hFFFF;
		random_phase(30, 40, 10);

		set_config('0, '0, '0, '0);
		random_phase(80, 3, -1);

		set_config('1, '1, '1, '1);
		random_phase(70, 60, -1);

		set_config(16'($urandom_range(0, 15)), 16'($urandom_range(0, 40)),
			16'($urandom_range(0, 100)), 16'($urandom_range(0, 40)));
		no_idle = 1'b1;
		random_phase(80, 12, -1);
		drain();
		no_idle = 1'b0;

		set_config(16'($urandom_range(1, 20)), 16'($urandom_range(1, 60)),
			16'($urandom_range(20, 200)), 16'($urandom_range(1, 50)));
		random_phase(80, 25, 20);

		set_config(PUSH_SETTLE_RST, RELEASE_SETTLE_RST, HOLD_DELAY_RST,
			REPEAT_PERIOD_RST);
		random_phase(70, 40, -1);
		drain();

		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

### filelist.f
hdl/bda_pkg.sv
hdl/bda_lane.sv
hdl/bda_merge.sv
hdl/button_debounce_autorepeat_top.sv
tb/button_debounce_autorepeat_top_test.sv
